[hdl/gcd_pkg.sv]
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared widths, constants and the CORDIC angle table for the great-circle
// distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int ANGLE_FRAC_BITS = 16;

  // Port field widths
  localparam int LAT_W  = 24;
  localparam int LON_W  = 25;
  localparam int DIST_W = 25;

  // Angle lanes: latitude A, latitude B, longitude difference
  localparam int NLANES   = 3;
  localparam int LANE_LA  = 0;
  localparam int LANE_LB  = 1;
  localparam int LANE_DLO = 2;

  localparam int DEG_W  = LON_W + 1;
  localparam int STEPS  = 30;

  // Degree to radian conversion: the magnitude never exceeds 90 degrees
  localparam int MAG_W  = ANGLE_FRAC_BITS + 7;
  localparam int PROD_W = MAG_W + 32;
  // Dividend left for the divide by 45; always 37 bits whatever the scale
  localparam int DIVN_W = PROD_W - ANGLE_FRAC_BITS - 2;
  localparam int SPLIT  = 19;
  localparam int HI_W   = DIVN_W - SPLIT;
  localparam int PHI_W  = HI_W + 32;
  localparam int PLO_W  = SPLIT + 32;
  localparam int SUM_W  = DIVN_W + 32;
  // floor(2^37 / 45): the estimate is exact or one short
  localparam logic [31:0] RECIP_45 = 32'd3054198966;
  localparam logic [DIVN_W-1:0] DIVISOR = DIVN_W'(45);

  localparam int CRD_W = 33;
  localparam int Z_W   = 32;
  localparam int AZ_W  = 31;
  localparam int SQ_W  = 61;
  localparam int ANG_W = 32;

  localparam logic signed [DEG_W:0] FULL_DEG    = (DEG_W+1)'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [DEG_W:0] HALF_DEG    = (DEG_W+1)'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [DEG_W:0] QUARTER_DEG = (DEG_W+1)'(90 << ANGLE_FRAC_BITS);

  localparam logic [31:0]             PI_Q30      = 32'd3373259426;
  localparam logic [30:0]             HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [CRD_W-1:0] CORDIC_K    = 33'sd652032874;
  localparam logic [22:0]             RADIUS_M    = 23'd6378137;
  localparam logic [DIST_W-1:0]       DIST_MAX    = 25'd20037509;

  typedef logic signed [LAT_W-1:0] lat_t;
  typedef logic signed [LON_W-1:0] lon_t;
  typedef logic [DIST_W-1:0]       dist_t;
  typedef logic signed [DEG_W-1:0] deg_t;
  typedef logic signed [CRD_W-1:0] crd_t;

  // atan(2^-i) in Q30; below 2^-10 the angle equals its tangent
  function automatic logic [30:0] atan_step(int i);
    logic [30:0] a;
    case (i)
      0:       a = 31'd843314857;
      1:       a = 31'd497837829;
      2:       a = 31'd263043837;
      3:       a = 31'd133525159;
      4:       a = 31'd67021687;
      5:       a = 31'd33543516;
      6:       a = 31'd16775851;
      7:       a = 31'd8388437;
      8:       a = 31'd4194283;
      9:       a = 31'd2097149;
      10:      a = 31'd1048576;
      default: a = 31'(1) << (30 - i);
    endcase
    return a;
  endfunction

endpackage

[hdl/gcd_if.sv]
// ----------------------------------------------------------------------------
// gcd_if
// Valid/ready channels for coordinate pairs and distances.
// ----------------------------------------------------------------------------
interface gcd_in_if import gcd_pkg::*; ();
  logic valid;
  logic ready;
  lat_t lat_a;
  lon_t lon_a;
  lat_t lat_b;
  lon_t lon_b;

  modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
  modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface gcd_out_if import gcd_pkg::*; ();
  logic  valid;
  logic  ready;
  dist_t distance_m;

  modport source (output valid, distance_m, input ready);
  modport sink   (input valid, distance_m, output ready);
endinterface

[hdl/gcd_trig.sv]
// ----------------------------------------------------------------------------
// gcd_trig
// Three lanes of degree reduction, radian conversion and pipelined rotation
// CORDIC giving Q30 cosine and sine.
// ----------------------------------------------------------------------------
module gcd_trig import gcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  deg_t deg_i [NLANES],
  output logic vld_o,
  output crd_t cos_o [NLANES],
  output crd_t sin_o [NLANES]
);

  localparam int LAT = STEPS + 6;

  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], vld_i};
    end
  end

  assign vld_o = vld_q[LAT-1];

  for (genvar l = 0; l < NLANES; l++) begin : g_lane
    logic signed [DEG_W:0] r0, r1, r2;
    logic                  flip_c;
    logic [DEG_W:0]        abs_c;
    logic [MAG_W-1:0]      mag_q;
    logic [3:0]            neg_q;
    logic [STEPS+4:0]      flip_q;
    logic [PROD_W-1:0]     prod_c;
    logic [DIVN_W-1:0]     nb_q, nc_q, nd_q;
    logic [PHI_W-1:0]      phi_q;
    logic [PLO_W-1:0]      plo_q;
    logic [SUM_W-1:0]      sum_c;
    logic [31:0]           qe_q;
    logic [DIVN_W-1:0]     q45_c, rem_c;
    logic [31:0]           qc_c;
    crd_t                  qs_c;
    crd_t                  x_q [STEPS+1];
    crd_t                  y_q [STEPS+1];
    crd_t                  z_q [STEPS+1];
    crd_t                  cos_q, sin_q;

    // Wrap into [-180, 180), then fold into [-90, 90] with a sign flip
    always_comb begin
      r0     = (DEG_W+1)'(deg_i[l]);
      flip_c = 1'b0;
      if (r0 >= HALF_DEG) begin
        r1 = r0 - FULL_DEG;
      end else if (r0 < -HALF_DEG) begin
        r1 = r0 + FULL_DEG;
      end else begin
        r1 = r0;
      end
      r2 = r1;
      if (r1 > QUARTER_DEG) begin
        r2     = r1 - HALF_DEG;
        flip_c = 1'b1;
      end else if (r1 < -QUARTER_DEG) begin
        r2     = r1 + HALF_DEG;
        flip_c = 1'b1;
      end
      abs_c = r2[DEG_W] ? unsigned'(-r2) : unsigned'(r2);
    end

    assign prod_c = PROD_W'(mag_q) * PROD_W'(PI_Q30) + PROD_W'(90 << ANGLE_FRAC_BITS);
    assign sum_c  = (SUM_W'(phi_q) << SPLIT) + SUM_W'(plo_q);
    assign q45_c  = (DIVN_W'(qe_q) << 5) + (DIVN_W'(qe_q) << 3) + (DIVN_W'(qe_q) << 2)
                  + DIVN_W'(qe_q);
    assign rem_c  = nd_q - q45_c;
    assign qc_c   = (rem_c >= DIVISOR) ? qe_q + 32'd1 : qe_q;
    assign qs_c   = signed'(CRD_W'(qc_c));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mag_q  <= abs_c[MAG_W-1:0];
        neg_q  <= {neg_q[2:0], r2[DEG_W]};
        flip_q <= {flip_q[STEPS+3:0], flip_c};
        nb_q   <= prod_c[PROD_W-1 -: DIVN_W];
        phi_q  <= PHI_W'(nb_q[DIVN_W-1:SPLIT]) * PHI_W'(RECIP_45);
        plo_q  <= PLO_W'(nb_q[SPLIT-1:0]) * PLO_W'(RECIP_45);
        nc_q   <= nb_q;
        qe_q   <= sum_c[SUM_W-1:DIVN_W];
        nd_q   <= nc_q;
        x_q[0] <= CORDIC_K;
        y_q[0] <= '0;
        z_q[0] <= neg_q[3] ? -qs_c : qs_c;
        cos_q  <= flip_q[STEPS+4] ? -x_q[STEPS] : x_q[STEPS];
        sin_q  <= flip_q[STEPS+4] ? -y_q[STEPS] : y_q[STEPS];
      end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam crd_t AT = signed'(CRD_W'(atan_step(i)));
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!z_q[i][CRD_W-1]) begin
            x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
            y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
            z_q[i+1] <= z_q[i] - AT;
          end else begin
            x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
            y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
            z_q[i+1] <= z_q[i] + AT;
          end
        end
      end
    end

    assign cos_o[l] = cos_q;
    assign sin_o[l] = sin_q;
  end

endmodule

[hdl/gcd_acos.sv]
// ----------------------------------------------------------------------------
// gcd_acos
// Pipelined arc cosine: bit-per-stage square root of 1 - z*z, then a
// vectoring CORDIC, clamp and mirror for negative z.
// ----------------------------------------------------------------------------
module gcd_acos import gcd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic signed [Z_W-1:0]   z_i,
  output logic                    vld_o,
  output logic [ANG_W-1:0]        ang_o
);

  localparam int SQ_STEPS = AZ_W;
  localparam int LAT      = 3 + SQ_STEPS + STEPS + 1;
  localparam int AZ_REGS  = 3 + SQ_STEPS;

  logic [LAT-1:0]   vld_q;
  logic [LAT-2:0]   neg_q;
  logic [AZ_W-1:0]  az_q [AZ_REGS];
  logic [2*AZ_W-1:0] az2_q;
  logic [SQ_W-1:0]  sv_q [SQ_STEPS+1];
  logic [SQ_W-1:0]  sr_q [SQ_STEPS+1];
  crd_t             vx [STEPS+1];
  crd_t             vy [STEPS+1];
  crd_t             va [STEPS+1];
  logic [30:0]      acc_c;
  logic [ANG_W-1:0] ang_q;
  logic signed [Z_W-1:0] zn_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], vld_i};
    end
  end

  assign vld_o = vld_q[LAT-1];
  assign zn_c  = -z_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q    <= {neg_q[LAT-3:0], z_i[Z_W-1]};
      az_q[0]  <= z_i[Z_W-1] ? zn_c[AZ_W-1:0] : z_i[AZ_W-1:0];
      for (int k = 1; k < AZ_REGS; k++) begin
        az_q[k] <= az_q[k-1];
      end
      az2_q    <= (2*AZ_W)'(az_q[0]) * (2*AZ_W)'(az_q[0]);
      sv_q[0]  <= (SQ_W'(1) << 60) - SQ_W'(az2_q);
      sr_q[0]  <= '0;
      ang_q    <= neg_q[LAT-2] ? PI_Q30 - ANG_W'(acc_c) : ANG_W'(acc_c);
    end
  end

  // Integer square root, one result bit per stage
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - j));
    logic [SQ_W-1:0] trial;
    assign trial = sr_q[j] + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (sv_q[j] >= trial) begin
          sv_q[j+1] <= sv_q[j] - trial;
          sr_q[j+1] <= (sr_q[j] >> 1) + BIT;
        end else begin
          sv_q[j+1] <= sv_q[j];
          sr_q[j+1] <= sr_q[j] >> 1;
        end
      end
    end
  end

  assign vx[0] = signed'(CRD_W'(az_q[AZ_REGS-1]));
  assign vy[0] = signed'(CRD_W'(sr_q[SQ_STEPS][AZ_W-1:0]));
  assign va[0] = '0;

  // Vectoring CORDIC: drive y to zero and sum the angle
  for (genvar i = 0; i < STEPS; i++) begin : g_vec
    localparam crd_t AT = signed'(CRD_W'(atan_step(i)));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (vy[i] > 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          va[i+1] <= va[i] + AT;
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          va[i+1] <= va[i] - AT;
        end
      end
    end
  end

  // Clamp to [0, pi/2]
  always_comb begin
    if (va[STEPS][CRD_W-1]) begin
      acc_c = '0;
    end else if (va[STEPS] > signed'(CRD_W'(HALF_PI_Q30))) begin
      acc_c = HALF_PI_Q30;
    end else begin
      acc_c = va[STEPS][30:0];
    end
  end

  assign ang_o = ang_q;

endmodule

[hdl/great_circle_distance.sv]
// ----------------------------------------------------------------------------
// great_circle_distance
// Great-circle distance in whole metres between two points given in signed
// fixed-point degrees, by the spherical law of cosines on a 6378137 m sphere.
// ----------------------------------------------------------------------------
// One coordinate pair enters per clock and one distance word leaves per
// clock while the skid word is free; the block keeps no state between pairs.
// After the input register, which loads at the accepting edge, each pair
// passes a chain of fully pipelined stages: 36 stages of angle reduction,
// radian conversion and 30-stage rotation CORDIC (three lanes in parallel),
// four stages forming z, 65 stages of arc cosine (31-stage square root and
// 30-stage vectoring CORDIC), two stages of scaling to metres and the
// output register. The whole pipeline advances together; a two-deep output
// buffer (output register plus skid word) absorbs one word while the sink
// stalls and halts the pipeline once the skid word is full, so input ready
// is a register and never waits on output ready.
// Angles wrap modulo 360 degrees for any input bit pattern.
// ----------------------------------------------------------------------------
module great_circle_distance import gcd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  gcd_in_if.sink    in_i,
  gcd_out_if.source out_o
);

  localparam int PW = 2 * CRD_W;

  logic en;

  // Input register
  logic in_vld_q;
  deg_t deg_q [NLANES];

  // Trig outputs
  logic trig_vld;
  crd_t cos_w [NLANES];
  crd_t sin_w [NLANES];

  // z formation
  logic                   p1_vld_q, p2_vld_q, p3_vld_q, p4_vld_q;
  logic signed [PW-1:0]   pss1_q, pcc1_q, pss2_q, pss3_q, ptc3_q;
  logic [PW-1:0]          tsum_c;
  crd_t                   cd1_q, cd2_q, t2_q;
  logic signed [PW:0]     z60_c, zs_c;
  logic signed [Z_W-1:0]  z4_q;

  // Arc cosine and scaling
  logic             ac_vld;
  logic [ANG_W-1:0] ang_w;
  logic             q1_vld_q, q2_vld_q;
  logic [ANG_W+22:0] dprod_q;
  logic [ANG_W+23:0] dround_c;
  dist_t            dist_q;

  // Output buffer
  logic  out_vld_q, skid_vld_q;
  dist_t out_q, skid_q;

  // Advance the whole pipeline whenever the skid word is free
  assign en       = ~skid_vld_q;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
      q1_vld_q <= 1'b0;
      q2_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= in_i.valid;
      p1_vld_q <= trig_vld;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      p4_vld_q <= p3_vld_q;
      q1_vld_q <= ac_vld;
      q2_vld_q <= q1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_q[LANE_LA]  <= DEG_W'(in_i.lat_a);
      deg_q[LANE_LB]  <= DEG_W'(in_i.lat_b);
      deg_q[LANE_DLO] <= DEG_W'(in_i.lon_b) - DEG_W'(in_i.lon_a);
    end
  end

  gcd_trig u_trig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_vld_q),
    .deg_i  (deg_q),
    .vld_o  (trig_vld),
    .cos_o  (cos_w),
    .sin_o  (sin_w)
  );

  // z = sinA sinB + round(cosA cosB) cos(dlon), rounded to Q30 and clamped
  assign tsum_c = pcc1_q + PW'(1 << 29);
  assign z60_c  = (PW+1)'(pss3_q) + (PW+1)'(ptc3_q) + (PW+1)'(1 << 29);
  assign zs_c   = z60_c >>> 30;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pss1_q <= PW'(sin_w[LANE_LA]) * PW'(sin_w[LANE_LB]);
      pcc1_q <= PW'(cos_w[LANE_LA]) * PW'(cos_w[LANE_LB]);
      cd1_q  <= cos_w[LANE_DLO];
      t2_q   <= tsum_c[30 +: CRD_W];
      pss2_q <= pss1_q;
      cd2_q  <= cd1_q;
      ptc3_q <= PW'(t2_q) * PW'(cd2_q);
      pss3_q <= pss2_q;
      if (zs_c > (PW+1)'(1 << 30)) begin
        z4_q <= Z_W'(1 << 30);
      end else if (zs_c < -(PW+1)'(1 << 30)) begin
        z4_q <= -Z_W'(1 << 30);
      end else begin
        z4_q <= zs_c[Z_W-1:0];
      end
    end
  end

  gcd_acos u_acos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (p4_vld_q),
    .z_i    (z4_q),
    .vld_o  (ac_vld),
    .ang_o  (ang_w)
  );

  // Scale to metres, round half up, cap at half the circumference
  assign dround_c = (ANG_W+24)'(dprod_q) + (ANG_W+24)'(1 << 29);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dprod_q <= (ANG_W+23)'(ang_w) * (ANG_W+23)'(RADIUS_M);
      if (dround_c[ANG_W+23:30] > (ANG_W-6)'(DIST_MAX)) begin
        dist_q <= DIST_MAX;
      end else begin
        dist_q <= dround_c[30 +: DIST_W];
      end
    end
  end

  // Output register with skid word: drain skid first, else take the
  // pipeline's word into whichever slot is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_o.ready) begin
        skid_vld_q <= 1'b0;
      end
    end else if (q2_vld_q) begin
      if (!out_vld_q || out_o.ready) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_o.ready) begin
        out_q <= skid_q;
      end
    end else if (q2_vld_q) begin
      if (!out_vld_q || out_o.ready) begin
        out_q <= dist_q;
      end else begin
        skid_q <= dist_q;
      end
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.distance_m = out_q;

endmodule
